### sv/dse_pkg.sv
// Shared types, constants and helper functions for the delimited segment extractor.
`default_nettype none
package dse_pkg;

  // Longest delimiter the window can match
  localparam int MAX_DELIM = 8;
  localparam int IDX_W     = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
  localparam int LEN_W     = 4;
  localparam int PAT_W     = 64;
  localparam int CFG_IDX_W = 3;

  // Result queue sizing (holds four results; a processed byte pushes up to two)
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PATTERN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_LENGTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PATTERN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_LENGTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALL_SEGMENTS  = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_CLOSED    = 2'd1;
  localparam logic [1:0] KIND_ABANDONED = 2'd2;

  typedef enum logic [1:0] {
    PH_SEEK = 2'd0,
    PH_SEG  = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    logic [PAT_W-1:0] left_pattern;
    logic [LEN_W-1:0] left_length;
    logic [PAT_W-1:0] right_pattern;
    logic [LEN_W-1:0] right_length;
    logic             all_segments;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic       last;
  } result_t;

  // Results produced by one byte, slot 0 first
  typedef struct packed {
    logic [1:0] count;
    result_t    res1;
    result_t    res0;
  } push_t;

  // Newest byte at entry 0
  typedef logic [MAX_DELIM-1:0][7:0] window_t;

  function automatic logic [LEN_W-1:0] clip_len(input logic [LEN_W-1:0] len);
    return (len > LEN_W'(MAX_DELIM)) ? LEN_W'(MAX_DELIM) : len;
  endfunction

  function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
    return (v == '1) ? v : v + LEN_W'(1);
  endfunction

  // Compare the newest len bytes against the pattern, first char oldest
  function automatic logic win_match(input window_t w, input logic [PAT_W-1:0] pat,
                                     input logic [LEN_W-1:0] len);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MAX_DELIM; i++) begin
      if (LEN_W'(i) < len) begin
        if (w[IDX_W'(len - LEN_W'(1) - LEN_W'(i))] != pat[8*i +: 8]) ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage
`default_nettype wire

### sv/dse_cfg_regs.sv
// Configuration register bank for the delimited segment extractor.
`default_nettype none
module dse_cfg_regs
  import dse_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAT_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  // Register writes, one index per beat
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_pattern  <= '0;
      cfg.left_length   <= '0;
      cfg.right_pattern <= '0;
      cfg.right_length  <= '0;
      cfg.all_segments  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEFT_PATTERN:  cfg.left_pattern  <= cfg_data;
        REG_LEFT_LENGTH:   cfg.left_length   <= cfg_data[LEN_W-1:0];
        REG_RIGHT_PATTERN: cfg.right_pattern <= cfg_data;
        REG_RIGHT_LENGTH:  cfg.right_length  <= cfg_data[LEN_W-1:0];
        REG_ALL_SEGMENTS:  cfg.all_segments  <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/dse_core.sv
// Input register, byte window, delimiter match and segment phase tracking.
`default_nettype none
module dse_core
  import dse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cfg_t       cfg,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,
  input  wire logic       s_tlast,
  input  wire logic       space,
  output logic            push_en,
  output push_t           push
);

  logic           in_valid;
  logic [7:0]     in_char;
  logic           in_last;
  window_t        win;
  window_t        win_next;
  phase_t         phase;
  phase_t         phase_next;
  logic [LEN_W-1:0] cnt;
  logic [LEN_W-1:0] cnt_next;

  logic [LEN_W-1:0] nl;
  logic [LEN_W-1:0] nr;
  logic [LEN_W-1:0] hold;
  logic [LEN_W-1:0] c_left;
  logic [LEN_W-1:0] c_seg;
  logic [LEN_W-1:0] seg_base;
  logic             do_seg;
  logic             left_hit;
  logic             right_hit;
  logic [1:0]       end_kind;
  result_t          data_res;
  result_t          end_res;

  assign push_en  = in_valid && space;
  assign s_tready = !in_valid || push_en;

  // Input beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Window shift and delimiter compares
  always_comb begin
    win_next[0] = in_char;
    for (int k = 1; k < MAX_DELIM; k++) win_next[k] = win[k-1];
  end

  assign nl        = clip_len(cfg.left_length);
  assign nr        = clip_len(cfg.right_length);
  assign hold      = (nr == '0) ? '0 : nr - LEN_W'(1);
  assign left_hit  = win_match(win_next, cfg.left_pattern, nl);
  assign right_hit = win_match(win_next, cfg.right_pattern, nr);
  assign end_kind  = (nr == '0) ? KIND_CLOSED : KIND_ABANDONED;

  always_comb begin
    data_res.kind = KIND_DATA;
    data_res.ch   = win_next[IDX_W'(hold)];
    data_res.last = 1'b0;
    end_res.kind  = end_kind;
    end_res.ch    = '0;
    end_res.last  = 1'b1;
  end

  // Phase, count and result selection for the byte in the input register
  always_comb begin
    phase_next = phase;
    cnt_next   = cnt;
    push       = '0;
    do_seg     = 1'b0;
    seg_base   = cnt;
    c_left     = sat_inc(cnt);
    case (phase)
      PH_SEEK: begin
        if (nl == '0) begin
          do_seg   = 1'b1;
          seg_base = '0;
        end else begin
          cnt_next = c_left;
          if (c_left >= nl && left_hit) begin
            phase_next = PH_SEG;
            cnt_next   = '0;
            if (in_last) begin
              push.res0  = end_res;
              push.count = 2'd1;
            end
          end
        end
      end
      PH_SEG:  do_seg = 1'b1;
      default: ;
    endcase

    c_seg = sat_inc(seg_base);
    if (do_seg) begin
      if (nr != '0 && c_seg >= nr && right_hit) begin
        push.res0      = end_res;
        push.res0.kind = KIND_CLOSED;
        push.res0.last = 1'b1;
        push.count     = 2'd1;
        phase_next     = cfg.all_segments ? PH_SEEK : PH_DONE;
        cnt_next       = '0;
      end else begin
        phase_next = PH_SEG;
        cnt_next   = c_seg;
        if (c_seg > hold) begin
          push.res0      = data_res;
          push.res0.last = !in_last;
          push.count     = 2'd1;
          if (in_last) begin
            push.res1  = end_res;
            push.count = 2'd2;
          end
        end else if (in_last) begin
          push.res0  = end_res;
          push.count = 2'd1;
        end
      end
    end

    // Every string starts fresh
    if (in_last) begin
      phase_next = PH_SEEK;
      cnt_next   = '0;
    end
  end

  // State update per processed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= '0;
      phase <= PH_SEEK;
      cnt   <= '0;
    end else if (push_en) begin
      win   <= win_next;
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

### sv/dse_out_fifo.sv
// Result queue: takes up to two results per cycle, hands out one beat per cycle while m_tready is high.
`default_nettype none
module dse_out_fifo
  import dse_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_en,
  input  wire push_t      push,
  output logic            space,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,
  output logic [1:0]      m_tuser,
  output logic            m_tlast
);

  result_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] n_in;
  logic             pop;

  assign n_in     = push_en ? CNT_W'(push.count) : '0;
  assign pop      = m_tvalid && m_tready;
  assign space    = count <= CNT_W'(FIFO_DEPTH - 2);
  assign m_tvalid = count != '0;
  assign m_tdata  = mem[head].ch;
  assign m_tuser  = mem[head].kind;
  assign m_tlast  = mem[head].last;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      tail  <= tail + PTR_W'(n_in);
      head  <= head + PTR_W'(pop);
      count <= count + n_in - CNT_W'(pop);
    end
  end

  // Entry writes
  always_ff @(posedge clk) begin
    if (push_en && push.count != 2'd0) mem[tail] <= push.res0;
    if (push_en && push.count == 2'd2) mem[tail + PTR_W'(1)] <= push.res1;
  end

endmodule
`default_nettype wire

### sv/delimited_segment_extractor_top.sv
// Delimited segment extractor: top level tying config, core and result queue.
// Path: the first result of a byte goes through the input register, then a queue
// entry, before it is offered; it waits while the result queue lacks space.
// Throughput: one byte per cycle while the result queue has space; a byte with
// two results needs two output beats, as the queue hands out one beat at a time.
// Reset (rst, synchronous): registers to reset values, window cleared,
// phase to seeking, queue emptied.
`default_nettype none
module delimited_segment_extractor_top
  import dse_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAT_W-1:0]     cfg_data,
  // Input stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] char_in
  input  wire logic                 s_tlast,   // string_end
  // Result stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [7:0]                m_tdata,   // [7:0] char_out
  output logic [1:0]                m_tuser,   // [1:0] kind
  output logic                      m_tlast    // run_last
);

  cfg_t  cfg;
  push_t push;
  logic  push_en;
  logic  space;

  dse_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dse_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .space    (space),
    .push_en  (push_en),
    .push     (push)
  );

  dse_out_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_en  (push_en),
    .push     (push),
    .space    (space),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
